// ----- rtl/pps_pkg.sv -----
// Shared types, constants and helpers for the priority pattern sequencer
package pps_pkg;

  localparam int DEF_PATTERN_TICKS = 64;
  localparam int DEF_LEVELS        = 3;

  localparam int LVL_W    = 2;
  localparam int TICK_IN_W = 6;
  localparam int DUR_W    = 2;
  localparam int ENTRY_W  = 8;
  localparam int GAP_W    = 8;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_ANALYZE = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  localparam logic [DUR_W-1:0] DUR_NONE  = 2'd0;
  localparam logic [DUR_W-1:0] DUR_SHORT = 2'd1;
  localparam logic [DUR_W-1:0] DUR_LONG  = 2'd2;
  localparam logic [DUR_W-1:0] DUR_SPARE = 2'd3;

  localparam logic KIND_TICK     = 1'b0;
  localparam logic KIND_ANALYSIS = 1'b1;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [LVL_W-1:0]     level;
    logic [TICK_IN_W-1:0] tick_index;
    logic [DUR_W-1:0]     dur_a;
    logic [DUR_W-1:0]     dur_b;
    logic [DUR_W-1:0]     dur_c;
    logic [DUR_W-1:0]     dur_d;
  } in_item_t;

  typedef struct packed {
    logic             result_kind;
    logic [DUR_W-1:0] fire_a;
    logic [DUR_W-1:0] fire_b;
    logic [DUR_W-1:0] fire_c;
    logic [DUR_W-1:0] fire_d;
    logic [LVL_W-1:0] level_used;
  } result_t;

  typedef struct packed {
    logic [GAP_W-1:0] ticks_per_long;
    logic [GAP_W-1:0] ticks_per_short;
    logic [LVL_W-1:0] min_level;
    logic [LVL_W-1:0] max_level;
  } cfg_t;

  typedef struct packed {
    logic en;
    logic wrap;
    logic prev_long;
  } gap_ctl_t;

  function automatic logic [DUR_W-1:0] sat_dur(input logic [DUR_W-1:0] d);
    return (d == DUR_SPARE) ? DUR_LONG : d;
  endfunction

  function automatic logic [DUR_W-1:0] chan_of(input logic [ENTRY_W-1:0] e,
                                               input logic [1:0] c);
    logic [DUR_W-1:0] d;
    unique case (c)
      2'd0: d = e[1:0];
      2'd1: d = e[3:2];
      2'd2: d = e[5:4];
      2'd3: d = e[7:6];
      default: d = DUR_NONE;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/pps_cfg.sv -----
// APB-style configuration registers
module pps_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pps_pkg::PADDR_W-1:0]   paddr,
  input  logic [pps_pkg::PDATA_W-1:0]   pwdata,
  output logic [pps_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output pps_pkg::cfg_t                 cfg
);
  import pps_pkg::*;

  localparam logic [1:0] REG_TPL  = 2'd0;
  localparam logic [1:0] REG_TPS  = 2'd1;
  localparam logic [1:0] REG_MINL = 2'd2;
  localparam logic [1:0] REG_MAXL = 2'd3;

  logic [1:0] reg_idx;
  logic       wr_xfer;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_xfer = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_long  <= '0;
      cfg.ticks_per_short <= '0;
      cfg.min_level       <= LVL_W'(0);
      cfg.max_level       <= LVL_W'(2);
    end else if (wr_xfer) begin
      unique case (reg_idx)
        REG_TPL:  cfg.ticks_per_long  <= pwdata[GAP_W-1:0];
        REG_TPS:  cfg.ticks_per_short <= pwdata[GAP_W-1:0];
        REG_MINL: cfg.min_level       <= pwdata[LVL_W-1:0];
        REG_MAXL: cfg.max_level       <= pwdata[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TPL:  prdata = PDATA_W'(cfg.ticks_per_long);
      REG_TPS:  prdata = PDATA_W'(cfg.ticks_per_short);
      REG_MINL: prdata = PDATA_W'(cfg.min_level);
      REG_MAXL: prdata = PDATA_W'(cfg.max_level);
      default:  prdata = '0;
    endcase
  end

endmodule

// ----- rtl/pps_store.sv -----
// Pattern table memory with per-entry valid bits
module pps_store #(
  parameter int  PATTERN_TICKS = pps_pkg::DEF_PATTERN_TICKS,
  parameter int  LEVELS        = pps_pkg::DEF_LEVELS,
  localparam int TICK_W        = $clog2(PATTERN_TICKS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [pps_pkg::LVL_W-1:0]     wr_level,
  input  logic [TICK_W-1:0]             wr_tick,
  input  logic [pps_pkg::ENTRY_W-1:0]   wr_data,
  input  logic                          rd_en,
  input  logic [pps_pkg::LVL_W-1:0]     rd_level,
  input  logic [TICK_W-1:0]             rd_tick,
  output logic [pps_pkg::ENTRY_W-1:0]   rd_data
);
  import pps_pkg::*;

  localparam int DEPTH  = LEVELS * PATTERN_TICKS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   vld;
  logic [ENTRY_W-1:0] data_q;
  logic               vld_q;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [LVL_W-1:0] lvl,
                                                input logic [TICK_W-1:0] tck);
    return ADDR_W'(lvl) * ADDR_W'(PATTERN_TICKS) + ADDR_W'(tck);
  endfunction

  assign wr_addr = addr_of(wr_level, wr_tick);
  assign rd_addr = addr_of(rd_level, rd_tick);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= vld[rd_addr];
      end
    end
  end

  assign rd_data = vld_q ? data_q : '0;

endmodule

// ----- rtl/pps_gap_unit.sv -----
// Shared gap subtractor and minimum compare
module pps_gap_unit #(
  parameter int  PATTERN_TICKS = pps_pkg::DEF_PATTERN_TICKS,
  localparam int TICK_W        = $clog2(PATTERN_TICKS)
) (
  input  pps_pkg::gap_ctl_t           ctl,
  input  logic [TICK_W-1:0]           tick_now,
  input  logic [TICK_W-1:0]           last_tick,
  input  logic [TICK_W-1:0]           first_tick,
  input  logic [pps_pkg::GAP_W-1:0]   lg_in,
  input  logic [pps_pkg::GAP_W-1:0]   sg_in,
  output logic [pps_pkg::GAP_W-1:0]   lg_out,
  output logic [pps_pkg::GAP_W-1:0]   sg_out
);
  import pps_pkg::*;

  logic [GAP_W-1:0] gap;

  always_comb begin
    if (ctl.wrap) begin
      gap = GAP_W'(PATTERN_TICKS - 1) - GAP_W'(last_tick) + GAP_W'(first_tick);
    end else begin
      gap = GAP_W'(tick_now) - GAP_W'(last_tick) - GAP_W'(1);
    end
    lg_out = lg_in;
    sg_out = sg_in;
    if (ctl.en) begin
      if (ctl.prev_long) begin
        if (gap < lg_in) lg_out = gap;
      end else begin
        if (gap < sg_in) sg_out = gap;
      end
    end
  end

endmodule

// ----- rtl/priority_pattern_sequencer_core.sv -----
// Priority pattern sequencer: command port, sequencer and table analysis
//
// Items enter on start/item and are taken when start is high and busy is low.
// A write item with a level below LEVELS loads one table entry in its transfer
// cycle; busy stays low and no result follows. A tick item walks the levels,
// one per cycle, then reads the table once; its result is registered in S_TRES
// and appears on result with result_strobe. An analyze item scans the table
// one channel of one entry per cycle through a single shared gap unit, then
// makes a wrap-around pass over the four channels (S_AWRAP) and a commit step
// (S_ALEVEL) per level, with the result strobed in the cycle in which busy
// falls. Each result is held for exactly one cycle under result_strobe; the
// receiver cannot stall it. The configuration registers sit on the APB-style
// port; the user must write them only while the block is idle, and the block
// itself does not enforce it.
// Synchronous reset empties the table through per-entry valid bits at once,
// sets every gap threshold to the pattern length, both populated levels to 0,
// and the registers to their reset values.
module priority_pattern_sequencer_core #(
  parameter int PATTERN_TICKS = pps_pkg::DEF_PATTERN_TICKS,
  parameter int LEVELS        = pps_pkg::DEF_LEVELS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  pps_pkg::in_item_t             item,
  output logic                          result_strobe,
  output pps_pkg::result_t              result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pps_pkg::PADDR_W-1:0]   paddr,
  input  logic [pps_pkg::PDATA_W-1:0]   pwdata,
  output logic [pps_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import pps_pkg::*;

  localparam int TICK_W = $clog2(PATTERN_TICKS);
  localparam int LIDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [TICK_W-1:0] LAST_TICK = TICK_W'(PATTERN_TICKS - 1);
  localparam logic [LVL_W-1:0]  LAST_LVL  = LVL_W'(LEVELS - 1);
  localparam logic [GAP_W-1:0]  GAP_INIT  = GAP_W'(PATTERN_TICKS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK   = 3'd1;
  localparam logic [2:0] S_TRES   = 3'd2;
  localparam logic [2:0] S_ACHAN  = 3'd3;
  localparam logic [2:0] S_AWRAP  = 3'd4;
  localparam logic [2:0] S_ALEVEL = 3'd5;

  cfg_t cfg;

  logic [2:0]         state;
  logic [LVL_W-1:0]   p;
  logic [TICK_W-1:0]  t_q;
  logic               t_ok;
  logic [LVL_W-1:0]   lvl;
  logic [TICK_W-1:0]  tick;
  logic [1:0]         ch;
  logic [GAP_W-1:0]   lg;
  logic [GAP_W-1:0]   sg;
  logic [3:0]         seen;
  logic [3:0]         plong;
  logic [TICK_W-1:0]  first_tick [4];
  logic [TICK_W-1:0]  last_tick  [4];
  logic               any_q;
  logic               found;
  logic [GAP_W-1:0]   long_gap_needed  [LEVELS];
  logic [GAP_W-1:0]   short_gap_needed [LEVELS];
  logic [LVL_W-1:0]   lowest_populated;
  logic [LVL_W-1:0]   highest_populated;

  logic               accept;
  logic               wr_en;
  logic [ENTRY_W-1:0] wr_data;
  logic               rd_en;
  logic [LVL_W-1:0]   rd_level;
  logic [TICK_W-1:0]  rd_tick;
  logic [ENTRY_W-1:0] rd_data;
  logic [DUR_W-1:0]   cur_dur;
  logic               walk_up;
  logic [LVL_W-1:0]   clamp_p;
  logic [LVL_W-1:0]   c1;
  logic [LVL_W-1:0]   c2;
  logic [LVL_W-1:0]   c3;
  logic [ENTRY_W-1:0] tick_entry;
  gap_ctl_t           gctl;
  logic [GAP_W-1:0]   lg_next;
  logic [GAP_W-1:0]   sg_next;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign cur_dur = chan_of(rd_data, ch);
  assign wr_data = {sat_dur(item.dur_d), sat_dur(item.dur_c),
                    sat_dur(item.dur_b), sat_dur(item.dur_a)};
  assign tick_entry = t_ok ? rd_data : '0;

  assign walk_up = (3'(p) < 3'(LEVELS - 1)) &&
                   ((long_gap_needed[p[LIDX_W-1:0]] < cfg.ticks_per_long) ||
                    (short_gap_needed[p[LIDX_W-1:0]] < cfg.ticks_per_short));

  always_comb begin
    c1      = (cfg.min_level > p) ? cfg.min_level : p;
    c2      = (c1 < lowest_populated) ? lowest_populated : c1;
    c3      = (cfg.max_level < c2) ? cfg.max_level : c2;
    clamp_p = (c3 > highest_populated) ? highest_populated : c3;
  end

  always_comb begin
    wr_en    = accept && (item.opcode == OP_WRITE) &&
               (3'(item.level) < 3'(LEVELS)) &&
               (GAP_W'(item.tick_index) < GAP_W'(PATTERN_TICKS));
    rd_en    = 1'b0;
    rd_level = '0;
    rd_tick  = '0;
    gctl     = '0;
    unique case (state)
      S_IDLE: begin
        rd_en = accept && (item.opcode == OP_ANALYZE);
      end
      S_WALK: begin
        if (!walk_up) begin
          rd_en    = 1'b1;
          rd_level = clamp_p;
          rd_tick  = t_q;
        end
      end
      S_ACHAN: begin
        gctl.en        = (cur_dur != DUR_NONE) && seen[ch];
        gctl.prev_long = plong[ch];
        if (ch == 2'd3 && tick != LAST_TICK) begin
          rd_en    = 1'b1;
          rd_level = lvl;
          rd_tick  = tick + TICK_W'(1);
        end
      end
      S_AWRAP: begin
        gctl.en        = seen[ch];
        gctl.wrap      = 1'b1;
        gctl.prev_long = plong[ch];
      end
      S_ALEVEL: begin
        if (lvl != LAST_LVL) begin
          rd_en    = 1'b1;
          rd_level = lvl + LVL_W'(1);
        end
      end
      default: ;
    endcase
  end

  pps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pps_store #(
    .PATTERN_TICKS (PATTERN_TICKS),
    .LEVELS        (LEVELS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_level (item.level),
    .wr_tick  (TICK_W'(item.tick_index)),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_level (rd_level),
    .rd_tick  (rd_tick),
    .rd_data  (rd_data)
  );

  pps_gap_unit #(
    .PATTERN_TICKS (PATTERN_TICKS)
  ) u_gap (
    .ctl        (gctl),
    .tick_now   (tick),
    .last_tick  (last_tick[ch]),
    .first_tick (first_tick[ch]),
    .lg_in      (lg),
    .sg_in      (sg),
    .lg_out     (lg_next),
    .sg_out     (sg_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      result_strobe     <= 1'b0;
      lowest_populated  <= '0;
      highest_populated <= '0;
      found             <= 1'b0;
      any_q             <= 1'b0;
      seen              <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        long_gap_needed[i]  <= GAP_INIT;
        short_gap_needed[i] <= GAP_INIT;
      end
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && item.opcode == OP_TICK) begin
            p     <= '0;
            t_q   <= TICK_W'(item.tick_index);
            t_ok  <= (GAP_W'(item.tick_index) < GAP_W'(PATTERN_TICKS));
            state <= S_WALK;
          end else if (accept && item.opcode == OP_ANALYZE) begin
            lvl               <= '0;
            tick              <= '0;
            ch                <= '0;
            lg                <= GAP_INIT;
            sg                <= GAP_INIT;
            seen              <= '0;
            any_q             <= 1'b0;
            found             <= 1'b0;
            lowest_populated  <= '0;
            highest_populated <= '0;
            state             <= S_ACHAN;
          end
        end
        S_WALK: begin
          if (walk_up) begin
            p <= p + LVL_W'(1);
          end else begin
            p     <= clamp_p;
            state <= S_TRES;
          end
        end
        S_TRES: begin
          result_strobe      <= 1'b1;
          result.result_kind <= KIND_TICK;
          result.fire_a      <= chan_of(tick_entry, 2'd0);
          result.fire_b      <= chan_of(tick_entry, 2'd1);
          result.fire_c      <= chan_of(tick_entry, 2'd2);
          result.fire_d      <= chan_of(tick_entry, 2'd3);
          result.level_used  <= p;
          state              <= S_IDLE;
        end
        S_ACHAN: begin
          lg <= lg_next;
          sg <= sg_next;
          if (rd_data != '0) any_q <= 1'b1;
          if (cur_dur != DUR_NONE) begin
            if (!seen[ch]) begin
              seen[ch]       <= 1'b1;
              first_tick[ch] <= tick;
            end
            last_tick[ch] <= tick;
            plong[ch]     <= cur_dur[1];
          end
          ch <= ch + 2'd1;
          if (ch == 2'd3) begin
            if (tick == LAST_TICK) begin
              state <= S_AWRAP;
            end else begin
              tick <= tick + TICK_W'(1);
            end
          end
        end
        S_AWRAP: begin
          lg <= lg_next;
          sg <= sg_next;
          ch <= ch + 2'd1;
          if (ch == 2'd3) state <= S_ALEVEL;
        end
        S_ALEVEL: begin
          long_gap_needed[lvl[LIDX_W-1:0]]  <= lg;
          short_gap_needed[lvl[LIDX_W-1:0]] <= sg;
          if (any_q) begin
            if (!found) lowest_populated <= lvl;
            highest_populated <= lvl;
            found             <= 1'b1;
          end
          if (lvl == LAST_LVL) begin
            result_strobe <= 1'b1;
            result        <= '{result_kind: KIND_ANALYSIS, fire_a: DUR_NONE,
                              fire_b: DUR_NONE, fire_c: DUR_NONE,
                              fire_d: DUR_NONE, level_used: '0};
            state         <= S_IDLE;
          end else begin
            lvl   <= lvl + LVL_W'(1);
            tick  <= '0;
            ch    <= '0;
            lg    <= GAP_INIT;
            sg    <= GAP_INIT;
            seen  <= '0;
            any_q <= 1'b0;
            state <= S_ACHAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/sv/tb_priority_pattern_sequencer_core.sv -----
// Self-checking testbench for the priority pattern sequencer core
module tb_priority_pattern_sequencer_core;
  import pps_pkg::*;

  localparam int TICKS         = DEF_PATTERN_TICKS;
  localparam int LEVELS        = DEF_LEVELS;
  localparam int RANDOM_ITEMS  = 800;
  localparam int SETTLE_CYCLES = LEVELS + 8;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int ITEM_W        = $bits(in_item_t);

  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic [PADDR_W-1:0] ADDR_TICKS_LONG  = 4'h0;
  localparam logic [PADDR_W-1:0] ADDR_TICKS_SHORT = 4'h4;
  localparam logic [PADDR_W-1:0] ADDR_MIN_LEVEL   = 4'h8;
  localparam logic [PADDR_W-1:0] ADDR_MAX_LEVEL   = 4'hC;

  class firing_tracker;
    logic [ENTRY_W-1:0] pattern [LEVELS][TICKS];
    logic [GAP_W-1:0]   long_gap [LEVELS];
    logic [GAP_W-1:0]   short_gap [LEVELS];
    int unsigned        low_pop;
    int unsigned        high_pop;
    cfg_t               cfg;
    result_t            pending_fires [$];
    int unsigned        mismatches;

    function new();
      foreach (pattern[p, t]) pattern[p][t] = '0;
      foreach (long_gap[p]) begin
        long_gap[p]  = GAP_W'(TICKS);
        short_gap[p] = GAP_W'(TICKS);
      end
      low_pop  = 0;
      high_pop = 0;
      cfg.ticks_per_long  = '0;
      cfg.ticks_per_short = '0;
      cfg.min_level       = '0;
      cfg.max_level       = LVL_W'(2);
      mismatches = 0;
    endfunction

    function void set_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
      case (addr)
        ADDR_TICKS_LONG:  cfg.ticks_per_long  = data[GAP_W-1:0];
        ADDR_TICKS_SHORT: cfg.ticks_per_short = data[GAP_W-1:0];
        ADDR_MIN_LEVEL:   cfg.min_level       = data[LVL_W-1:0];
        ADDR_MAX_LEVEL:   cfg.max_level       = data[LVL_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [DUR_W-1:0] fold_spare(logic [DUR_W-1:0] d);
      return d[1] ? DUR_LONG : d;
    endfunction

    function void note_item(in_item_t it);
      int unsigned      first_t [4];
      int unsigned      last_t [4];
      logic [DUR_W-1:0] last_dur [4];
      bit               seen [4];
      bit               populated;
      bit               found;
      int unsigned      lg;
      int unsigned      sg;
      int unsigned      gap;
      int unsigned      lvl;
      logic [DUR_W-1:0] d;
      logic [ENTRY_W-1:0] e;
      result_t          r;
      r = '0;
      case (it.opcode)
        OP_WRITE: begin
          if (it.level < LEVELS)
            pattern[it.level][it.tick_index] = {fold_spare(it.dur_d), fold_spare(it.dur_c),
                                                fold_spare(it.dur_b), fold_spare(it.dur_a)};
        end
        OP_ANALYZE: begin
          found    = 0;
          low_pop  = 0;
          high_pop = 0;
          for (int p = 0; p < LEVELS; p++) begin
            lg = TICKS;
            sg = TICKS;
            populated = 0;
            for (int c = 0; c < 4; c++) seen[c] = 0;
            for (int t = 0; t < TICKS; t++) begin
              if (pattern[p][t] != '0) populated = 1;
              for (int c = 0; c < 4; c++) begin
                d = pattern[p][t][2*c +: DUR_W];
                if (d != DUR_NONE) begin
                  if (!seen[c]) begin
                    seen[c]    = 1;
                    first_t[c] = t;
                  end else begin
                    gap = t - 1 - last_t[c];
                    if (last_dur[c] == DUR_LONG) begin
                      if (gap < lg) lg = gap;
                    end else begin
                      if (gap < sg) sg = gap;
                    end
                  end
                  last_t[c]   = t;
                  last_dur[c] = d;
                end
              end
            end
            // wrap from the last firing round to the first
            for (int c = 0; c < 4; c++) begin
              if (seen[c]) begin
                gap = TICKS - 1 - last_t[c] + first_t[c];
                if (last_dur[c] == DUR_LONG) begin
                  if (gap < lg) lg = gap;
                end else begin
                  if (gap < sg) sg = gap;
                end
              end
            end
            long_gap[p]  = GAP_W'(lg);
            short_gap[p] = GAP_W'(sg);
            if (populated) begin
              if (!found) low_pop = p;
              high_pop = p;
              found    = 1;
            end
          end
          r.result_kind = KIND_ANALYSIS;
          pending_fires.push_back(r);
        end
        OP_TICK: begin
          lvl = 0;
          while (lvl < LEVELS - 1 && (long_gap[lvl] < cfg.ticks_per_long ||
                                      short_gap[lvl] < cfg.ticks_per_short))
            lvl++;
          if (cfg.min_level > lvl) lvl = cfg.min_level;
          if (lvl < low_pop) lvl = low_pop;
          if (cfg.max_level < lvl) lvl = cfg.max_level;
          if (lvl > high_pop) lvl = high_pop;
          e = pattern[lvl][it.tick_index];
          r.result_kind = KIND_TICK;
          r.fire_a      = e[1:0];
          r.fire_b      = e[3:2];
          r.fire_c      = e[5:4];
          r.fire_d      = e[7:6];
          r.level_used  = LVL_W'(lvl);
          pending_fires.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check(result_t got);
      result_t want;
      if (pending_fires.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: kind %0d fire %0d %0d %0d %0d level %0d",
                   got.result_kind, got.fire_a, got.fire_b, got.fire_c, got.fire_d,
                   got.level_used);
        mismatches++;
      end else begin
        want = pending_fires.pop_front();
        if (got.result_kind !== want.result_kind || got.fire_a !== want.fire_a ||
            got.fire_b !== want.fire_b || got.fire_c !== want.fire_c ||
            got.fire_d !== want.fire_d || got.level_used !== want.level_used) begin
          if (mismatches < 10)
            $display({"mismatch: expected kind %0d fire %0d %0d %0d %0d level %0d,",
                      " got kind %0d fire %0d %0d %0d %0d level %0d"},
                     want.result_kind, want.fire_a, want.fire_b, want.fire_c, want.fire_d,
                     want.level_used, got.result_kind, got.fire_a, got.fire_b, got.fire_c,
                     got.fire_d, got.level_used);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  in_item_t            item = '0;
  logic                result_strobe;
  result_t             result;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  firing_tracker tracker = new();
  bit            steady = 1'b0;
  int unsigned   n_sent = 0;
  int unsigned   cycle_count = 0;

  priority_pattern_sequencer_core i_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_strobe === 1'b1) tracker.check(result);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic in_item_t make_item(logic [1:0] op, logic [LVL_W-1:0] lvl,
                                         logic [TICK_IN_W-1:0] tick,
                                         logic [DUR_W-1:0] a, logic [DUR_W-1:0] b,
                                         logic [DUR_W-1:0] c, logic [DUR_W-1:0] d);
    in_item_t it;
    it.opcode     = op;
    it.level      = lvl;
    it.tick_index = tick;
    it.dur_a      = a;
    it.dur_b      = b;
    it.dur_c      = c;
    it.dur_d      = d;
    return it;
  endfunction

  function automatic logic [DUR_W-1:0] rand_dur();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return DUR_NONE;
    if (r < 80) return DUR_SHORT;
    if (r < 95) return DUR_LONG;
    return DUR_SPARE;
  endfunction

  function automatic logic [GAP_W-1:0] rand_tempo();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return '0;
    if (r < 40) return '1;
    return GAP_W'($urandom_range(70));
  endfunction

  task automatic send_item(in_item_t it);
    steady = (n_sent >= 330 && n_sent < 480);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 35) begin
      start <= 1'b0;
      item  <= in_item_t'(ITEM_W'($urandom));
      @(negedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_item(it);
    if (it.opcode != OP_SPARE && !(it.opcode == OP_WRITE && it.level >= LEVELS)) n_sent++;
  endtask

  // drop start and let the block settle before touching the registers
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending_fires.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    tracker.set_reg(addr, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic retune();
    drain();
    if ($urandom_range(9) < 6) write_reg(ADDR_TICKS_LONG, PDATA_W'(rand_tempo()));
    if ($urandom_range(9) < 6) write_reg(ADDR_TICKS_SHORT, PDATA_W'(rand_tempo()));
    if ($urandom_range(9) < 6) write_reg(ADDR_MIN_LEVEL, PDATA_W'($urandom_range(2)));
    if ($urandom_range(9) < 6) write_reg(ADDR_MAX_LEVEL, PDATA_W'($urandom_range(2)));
  endtask

  initial begin
    in_item_t         it;
    logic [LVL_W-1:0] home;
    int unsigned      r;
    int unsigned      len;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // empty table, then a sparse table with single firings and spare codes
    send_item(make_item(OP_ANALYZE, 2'd0, 6'd0, DUR_NONE, DUR_NONE, DUR_NONE, DUR_NONE));
    send_item(make_item(OP_TICK, 2'd0, 6'd0, DUR_NONE, DUR_NONE, DUR_NONE, DUR_NONE));
    send_item(make_item(OP_TICK, 2'd0, 6'd63, DUR_NONE, DUR_NONE, DUR_NONE, DUR_NONE));
    send_item(make_item(OP_WRITE, 2'd0, 6'd0, DUR_NONE, DUR_SHORT, DUR_NONE, DUR_NONE));
    send_item(make_item(OP_WRITE, 2'd0, 6'd10, DUR_LONG, DUR_SHORT, DUR_NONE, DUR_NONE));
    send_item(make_item(OP_WRITE, 2'd1, 6'd5, DUR_LONG, DUR_NONE, DUR_NONE, DUR_NONE));
    send_item(make_item(OP_WRITE, 2'd1, 6'd63, DUR_SPARE, DUR_SPARE, DUR_SPARE, DUR_SPARE));
    send_item(make_item(OP_WRITE, 2'd2, 6'd63, DUR_NONE, DUR_NONE, DUR_NONE, DUR_SHORT));
    send_item(make_item(OP_WRITE, 2'd2, 6'd0, DUR_NONE, DUR_NONE, DUR_LONG, DUR_LONG));
    send_item(make_item(OP_WRITE, 2'd3, 6'd7, DUR_LONG, DUR_NONE, DUR_NONE, DUR_NONE));
    send_item(make_item(OP_SPARE, 2'd3, 6'd63, DUR_SPARE, DUR_SPARE, DUR_SPARE, DUR_SPARE));
    send_item(make_item(OP_TICK, 2'd3, 6'd63, DUR_SPARE, DUR_SPARE, DUR_SPARE, DUR_SPARE));
    send_item(make_item(OP_ANALYZE, 2'd3, 6'd63, DUR_SPARE, DUR_SPARE, DUR_SPARE, DUR_SPARE));
    send_item(make_item(OP_TICK, 2'd0, 6'd0, DUR_NONE, DUR_NONE, DUR_NONE, DUR_NONE));
    send_item(make_item(OP_TICK, 2'd0, 6'd10, DUR_NONE, DUR_NONE, DUR_NONE, DUR_NONE));
    send_item(make_item(OP_TICK, 2'd0, 6'd63, DUR_NONE, DUR_NONE, DUR_NONE, DUR_NONE));
    send_item(make_item(OP_TICK, 2'd0, 6'd5, DUR_NONE, DUR_NONE, DUR_NONE, DUR_NONE));

    drain();
    write_reg(ADDR_TICKS_LONG, 32'd255);
    write_reg(ADDR_TICKS_SHORT, 32'd255);
    write_reg(ADDR_MIN_LEVEL, 32'd0);
    write_reg(ADDR_MAX_LEVEL, 32'd2);
    send_item(make_item(OP_TICK, 2'd0, 6'd63, DUR_NONE, DUR_NONE, DUR_NONE, DUR_NONE));
    send_item(make_item(OP_TICK, 2'd0, 6'd0, DUR_NONE, DUR_NONE, DUR_NONE, DUR_NONE));

    drain();
    write_reg(ADDR_TICKS_LONG, 32'd0);
    write_reg(ADDR_TICKS_SHORT, 32'd0);
    write_reg(ADDR_MIN_LEVEL, 32'd2);
    write_reg(ADDR_MAX_LEVEL, 32'd2);
    send_item(make_item(OP_TICK, 2'd0, 6'd63, DUR_NONE, DUR_NONE, DUR_NONE, DUR_NONE));

    drain();
    write_reg(ADDR_MIN_LEVEL, 32'd0);
    write_reg(ADDR_MAX_LEVEL, 32'd0);
    send_item(make_item(OP_TICK, 2'd0, 6'd10, DUR_NONE, DUR_NONE, DUR_NONE, DUR_NONE));

    drain();
    write_reg(ADDR_TICKS_LONG, 32'd1);
    write_reg(ADDR_TICKS_SHORT, 32'd64);
    write_reg(ADDR_MAX_LEVEL, 32'd2);
    send_item(make_item(OP_TICK, 2'd0, 6'd5, DUR_NONE, DUR_NONE, DUR_NONE, DUR_NONE));

    while (n_sent < RANDOM_ITEMS) begin
      if ($urandom_range(3) == 0) retune();
      home = LVL_W'($urandom_range(LEVELS - 1));
      if ($urandom_range(11) == 0) begin
        // clear a whole level
        for (int t = 0; t < TICKS; t++)
          send_item(make_item(OP_WRITE, home, TICK_IN_W'(t),
                              DUR_NONE, DUR_NONE, DUR_NONE, DUR_NONE));
      end else begin
        len = $urandom_range(10, 40);
        repeat (len) begin
          r  = $urandom_range(99);
          it = in_item_t'(ITEM_W'($urandom));
          if (r < 42) begin
            it = make_item(OP_WRITE, home, TICK_IN_W'($urandom_range(TICKS - 1)),
                           rand_dur(), rand_dur(), rand_dur(), rand_dur());
            if ($urandom_range(3) == 0) it.level = LVL_W'($urandom_range(LEVELS - 1));
          end else if (r < 50) begin
            it.opcode = OP_ANALYZE;
          end else if (r < 93) begin
            it.opcode = OP_TICK;
          end else if (r < 97) begin
            it.opcode = OP_SPARE;
          end else begin
            it.opcode = OP_WRITE;
            it.level  = LVL_W'(3);
          end
          send_item(it);
        end
      end
      it = in_item_t'(ITEM_W'($urandom));
      it.opcode = OP_ANALYZE;
      send_item(it);
      repeat ($urandom_range(3, 6)) begin
        it = in_item_t'(ITEM_W'($urandom));
        it.opcode = OP_TICK;
        send_item(it);
      end
    end

    drain();
    if (tracker.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- priority_pattern_sequencer_core.f -----
rtl/pps_pkg.sv
rtl/pps_cfg.sv
rtl/pps_store.sv
rtl/pps_gap_unit.sv
rtl/priority_pattern_sequencer_core.sv
tb/sv/tb_priority_pattern_sequencer_core.sv
